// ===== design/qslerp_pkg.sv =====
// ----------------------------------------------------------------------------
// qslerp_pkg
// Shared types and constants of the quaternion slerp block: the word kinds
// set by the front end, the queue word, register indexes and CORDIC tables.
// ----------------------------------------------------------------------------
`default_nettype none

package qslerp_pkg;

    // How a word is finished in the back end.
    typedef enum logic [1:0] {
        KIND_FROM,
        KIND_TO,
        KIND_LINEAR,
        KIND_TRIG
    } kind_t;

    // Configuration register indexes.
    localparam logic REG_EQUAL_TOLERANCE    = 1'b0;
    localparam logic REG_PARALLEL_THRESHOLD = 1'b1;

    localparam logic [30:0] EQUAL_TOLERANCE_RESET    = 31'd10737;
    localparam logic [30:0] PARALLEL_THRESHOLD_RESET = 31'd1074;

    // One classified word as it travels from the front end to the back end.
    typedef struct packed {
        logic [3:0][31:0] f;
        logic [3:0][31:0] g;
        logic [31:0]      t;
        kind_t            kind;
        logic             c_neg;
        logic [30:0]      absc;
    } item_t;

    // Queue between front and back end.
    localparam int QUEUE_DEPTH = 8;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);
    // Front-end stages plus the word being accepted.
    localparam int QUEUE_SLACK = 4;

    typedef struct packed {
        logic                empty;
        logic                full;
        logic [QUEUE_CW-1:0] count;
    } queue_status_t;

    // CORDIC constants, all in Q30.
    localparam int CORDIC_STEPS = 31;
    localparam int DIV_STEPS    = 31;
    localparam logic [30:0] ONE_30     = 31'h4000_0000;
    localparam logic [30:0] INV_GAIN   = 31'd652032874;

    localparam logic [30:0] ATAN_TAB [CORDIC_STEPS] = '{
        31'd843314857, 31'd497837829, 31'd263043837, 31'd133525159, 31'd67021687,
        31'd33543516, 31'd16775851, 31'd8388437, 31'd4194283, 31'd2097149,
        31'd1048576, 31'd524288, 31'd262144, 31'd131072, 31'd65536, 31'd32768,
        31'd16384, 31'd8192, 31'd4096, 31'd2048, 31'd1024, 31'd512, 31'd256,
        31'd128, 31'd64, 31'd32, 31'd16, 31'd8, 31'd4, 31'd2, 31'd1
    };

endpackage

`default_nettype wire

// ===== design/qslerp_front.sv =====
// ----------------------------------------------------------------------------
// qslerp_front
// Front end: registers each accepted word, forms the dot product and sorts
// the word into start, end, linear or trigonometric handling.
// ----------------------------------------------------------------------------
`default_nettype none

module qslerp_front
    import qslerp_pkg::*;
#(
    parameter int FRACTION_BITS = 30
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [3:0][31:0]  from_q,
    input  logic [3:0][31:0]  to_q,
    input  logic [31:0]       blend,
    input  logic [30:0]       equal_tolerance,
    input  logic [30:0]       parallel_threshold,
    output logic              push,
    output item_t             push_item
);

    localparam logic signed [31:0] ONE_F    = 32'(64'd1 << FRACTION_BITS);
    localparam logic signed [67:0] ONE_F_68 = 68'(68'd1 << FRACTION_BITS);

    logic             a_vld_reg;
    logic [3:0][31:0] a_f_reg, a_g_reg;
    logic [31:0]      a_t_reg;

    logic                    b_vld_reg;
    logic [3:0][31:0]        b_f_reg, b_g_reg;
    logic [31:0]             b_t_reg;
    logic signed [63:0]      b_prod_reg [4];
    logic                    b_le0_reg, b_ge1_reg, b_same_reg;

    logic               c_vld_reg;
    logic [3:0][31:0]   c_f_reg, c_g_reg;
    logic [31:0]        c_t_reg;
    logic signed [65:0] c_sum_reg;
    logic               c_le0_reg, c_ge1_reg, c_same_reg;

    logic [3:0]         same_w;
    logic signed [65:0] dot_w;
    logic signed [67:0] absc_w;
    logic               trig_w;

    // Valid bits of the three front stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
        end
        else
        begin
            a_vld_reg <= accept;
            b_vld_reg <= a_vld_reg;
            c_vld_reg <= b_vld_reg;
        end
    end

    // Per-component equality test against the tolerance.
    always_comb
    begin
        logic signed [32:0] d;
        logic [32:0]        ad;
        for (int k = 0; k < 4; k++)
        begin
            d  = $signed({a_f_reg[k][31], a_f_reg[k]}) - $signed({a_g_reg[k][31], a_g_reg[k]});
            ad = d[32] ? 33'(-d) : 33'(d);
            same_w[k] = (ad <= {2'b00, equal_tolerance});
        end
    end

    // Input capture, products and classification flags, then the sum.
    always_ff @(posedge clk)
    begin
        a_f_reg <= from_q;
        a_g_reg <= to_q;
        a_t_reg <= blend;

        b_f_reg    <= a_f_reg;
        b_g_reg    <= a_g_reg;
        b_t_reg    <= a_t_reg;
        for (int k = 0; k < 4; k++)
        begin
            b_prod_reg[k] <= $signed(a_f_reg[k]) * $signed(a_g_reg[k]);
        end
        b_le0_reg  <= ($signed(a_t_reg) <= 32'sd0);
        b_ge1_reg  <= ($signed(a_t_reg) >= ONE_F);
        b_same_reg <= &same_w;

        c_f_reg    <= b_f_reg;
        c_g_reg    <= b_g_reg;
        c_t_reg    <= b_t_reg;
        c_le0_reg  <= b_le0_reg;
        c_ge1_reg  <= b_ge1_reg;
        c_same_reg <= b_same_reg;
        c_sum_reg  <= 66'(b_prod_reg[0]) + 66'(b_prod_reg[1])
                    + 66'(b_prod_reg[2]) + 66'(b_prod_reg[3]);
    end

    // Dot product, its magnitude and the path choice.
    assign dot_w  = c_sum_reg >>> FRACTION_BITS;
    assign absc_w = dot_w[65] ? -68'(dot_w) : 68'(dot_w);
    assign trig_w = (ONE_F_68 - absc_w) > $signed({37'd0, parallel_threshold});

    always_comb
    begin
        push_item.f     = c_f_reg;
        push_item.g     = c_g_reg;
        push_item.t     = c_t_reg;
        push_item.c_neg = dot_w[65];
        push_item.absc  = absc_w[30:0];
        if (c_le0_reg)
        begin
            push_item.kind = KIND_FROM;
        end
        else if (c_ge1_reg || c_same_reg)
        begin
            push_item.kind = KIND_TO;
        end
        else if (trig_w)
        begin
            push_item.kind = KIND_TRIG;
        end
        else
        begin
            push_item.kind = KIND_LINEAR;
        end
    end

    assign push = c_vld_reg;

endmodule

`default_nettype wire

// ===== design/qslerp_queue.sv =====
// ----------------------------------------------------------------------------
// qslerp_queue
// Short first-in first-out queue that decouples the front end from the
// back end.
// ----------------------------------------------------------------------------
`default_nettype none

module qslerp_queue
    import qslerp_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  item_t         push_item,
    input  logic          pop,
    output item_t         head_item,
    output queue_status_t status
);

    item_t               mem_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QUEUE_CW-1:0] count_reg;
    logic                do_push, do_pop;

    assign do_push = push && (count_reg != QUEUE_CW'(QUEUE_DEPTH));
    assign do_pop  = pop && (count_reg != '0);

    // Storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    assign head_item    = mem_reg[rd_ptr_reg];
    assign status.empty = (count_reg == '0);
    assign status.full  = (count_reg == QUEUE_CW'(QUEUE_DEPTH));
    assign status.count = count_reg;

endmodule

`default_nettype wire

// ===== design/qslerp_back.sv =====
// ----------------------------------------------------------------------------
// qslerp_back
// Back end: square root, CORDIC arctangent and sines, weight division and
// the final weighted sum, one pipeline stage per step.
// ----------------------------------------------------------------------------
`default_nettype none

module qslerp_back
    import qslerp_pkg::*;
#(
    parameter int FRACTION_BITS = 30
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  item_t            in_item,
    output logic             done,
    output logic [3:0][31:0] result
);

    localparam int SQ_STEPS = FRACTION_BITS + 1;
    localparam int RAD_W    = 2 * SQ_STEPS;
    localparam int REM_W    = SQ_STEPS + 3;
    localparam int UP       = 30 - FRACTION_BITS;

    localparam int ST_SQ   = 0;
    localparam int ST_RAD  = ST_SQ + 1;
    localparam int ST_SQRT = ST_RAD + 1;
    localparam int ST_ATAN = ST_SQRT + SQ_STEPS;
    localparam int ST_ANG  = ST_ATAN + CORDIC_STEPS;
    localparam int ST_SIN  = ST_ANG + 1;
    localparam int ST_DIVC = ST_SIN + CORDIC_STEPS;
    localparam int ST_DIV  = ST_DIVC + 1;
    localparam int ST_WGT  = ST_DIV + DIV_STEPS;
    localparam int ST_PROD = ST_WGT + 1;
    localparam int NSTAGE  = ST_PROD + 1;

    localparam logic [SQ_STEPS-1:0] ONE_F_SQ = SQ_STEPS'(64'd1 << FRACTION_BITS);

    logic  vld_reg [NSTAGE];
    item_t bl_reg  [NSTAGE];

    logic [61:0]          sq_reg;
    logic [RAD_W-1:0]     rad_reg;
    logic [RAD_W-1:0]     sr_rad_reg  [SQ_STEPS];
    logic [REM_W-1:0]     sr_rem_reg  [SQ_STEPS];
    logic [SQ_STEPS-1:0]  sr_root_reg [SQ_STEPS];

    logic [30:0]          sn_ln_reg [ST_ATAN:ST_WGT-2];

    logic signed [33:0]   at_x_reg [CORDIC_STEPS];
    logic signed [33:0]   at_y_reg [CORDIC_STEPS];
    logic signed [32:0]   at_z_reg [CORDIC_STEPS];

    logic signed [32:0]   ang_reg [2];

    logic signed [33:0]   sn_x_reg [2][CORDIC_STEPS];
    logic signed [33:0]   sn_y_reg [2][CORDIC_STEPS];
    logic signed [32:0]   sn_z_reg [2][CORDIC_STEPS];

    logic [31:0]          dc_rem_reg [2];
    logic                 dc_bit_reg [2];
    logic                 dc_ovf_reg [2];

    logic [31:0]          dv_rem_reg [2][DIV_STEPS];
    logic [30:0]          dv_q_reg   [2][DIV_STEPS];
    logic                 dv_ovf_reg [2][DIV_STEPS];

    logic signed [31:0]   w0_reg, w1_reg;
    logic signed [63:0]   pr0_reg [4];
    logic signed [63:0]   pr1_reg [4];

    logic                 done_reg;
    logic [3:0][31:0]     out_reg;

    logic [30:0]          sn30_w;
    logic [30:0]          c30_w;

    // Valid line through every stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < NSTAGE; s++)
            begin
                vld_reg[s] <= 1'b0;
            end
            done_reg <= 1'b0;
        end
        else
        begin
            vld_reg[0] <= in_valid;
            for (int s = 1; s < NSTAGE; s++)
            begin
                vld_reg[s] <= vld_reg[s-1];
            end
            done_reg <= vld_reg[ST_PROD];
        end
    end

    // Word line and the square of |c|, then the radicand.
    always_ff @(posedge clk)
    begin
        logic [61:0]         csq;
        logic [SQ_STEPS-1:0] s;
        bl_reg[0] <= in_item;
        for (int i = 1; i < NSTAGE; i++)
        begin
            bl_reg[i] <= bl_reg[i-1];
        end
        sq_reg  <= {31'd0, in_item.absc} * {31'd0, in_item.absc};
        csq     = sq_reg >> FRACTION_BITS;
        s       = ONE_F_SQ - csq[SQ_STEPS-1:0];
        rad_reg <= {1'b0, s, {FRACTION_BITS{1'b0}}};
    end

    // Digit-by-digit square root, one root bit per stage.
    genvar k, l;
    generate
        for (k = 0; k < SQ_STEPS; k++)
        begin : g_sqrt
            logic [REM_W-1:0]    rem_in, r2, trial;
            logic [SQ_STEPS-1:0] root_in;
            logic [RAD_W-1:0]    rad_in;
            if (k == 0)
            begin : g_first
                assign rem_in  = '0;
                assign root_in = '0;
                assign rad_in  = rad_reg;
            end
            else
            begin : g_next
                assign rem_in  = sr_rem_reg[k-1];
                assign root_in = sr_root_reg[k-1];
                assign rad_in  = sr_rad_reg[k-1];
            end
            assign r2    = {rem_in[REM_W-3:0], rad_in[RAD_W-1-2*k -: 2]};
            assign trial = REM_W'({root_in, 2'b01});
            always_ff @(posedge clk)
            begin
                sr_rad_reg[k] <= rad_in;
                if (r2 >= trial)
                begin
                    sr_rem_reg[k]  <= r2 - trial;
                    sr_root_reg[k] <= {root_in[SQ_STEPS-2:0], 1'b1};
                end
                else
                begin
                    sr_rem_reg[k]  <= r2;
                    sr_root_reg[k] <= {root_in[SQ_STEPS-2:0], 1'b0};
                end
            end
        end
    endgenerate

    assign sn30_w = 31'(sr_root_reg[SQ_STEPS-1]) << UP;
    assign c30_w  = bl_reg[ST_ATAN-1].absc << UP;

    // The divisor travels alongside the CORDIC and divider stages.
    always_ff @(posedge clk)
    begin
        sn_ln_reg[ST_ATAN] <= sn30_w;
        for (int s = ST_ATAN + 1; s <= ST_WGT - 2; s++)
        begin
            sn_ln_reg[s] <= sn_ln_reg[s-1];
        end
    end

    // CORDIC vectoring for omega = atan2(sn, |c|).
    generate
        for (k = 0; k < CORDIC_STEPS; k++)
        begin : g_atan
            logic signed [33:0] x_in, y_in;
            logic signed [32:0] z_in;
            if (k == 0)
            begin : g_first
                assign x_in = $signed({3'b000, c30_w});
                assign y_in = $signed({3'b000, sn30_w});
                assign z_in = '0;
            end
            else
            begin : g_next
                assign x_in = at_x_reg[k-1];
                assign y_in = at_y_reg[k-1];
                assign z_in = at_z_reg[k-1];
            end
            always_ff @(posedge clk)
            begin
                if (y_in > 34'sd0)
                begin
                    at_x_reg[k] <= x_in + (y_in >>> k);
                    at_y_reg[k] <= y_in - (x_in >>> k);
                    at_z_reg[k] <= z_in + $signed({2'b00, ATAN_TAB[k]});
                end
                else
                begin
                    at_x_reg[k] <= x_in - (y_in >>> k);
                    at_y_reg[k] <= y_in + (x_in >>> k);
                    at_z_reg[k] <= z_in - $signed({2'b00, ATAN_TAB[k]});
                end
            end
        end
    endgenerate

    // Angles t*omega and (1-t)*omega.
    always_ff @(posedge clk)
    begin
        logic [30:0] om, t30;
        logic [61:0] m0, m1;
        om  = at_z_reg[CORDIC_STEPS-1][32] ? 31'd0 : at_z_reg[CORDIC_STEPS-1][30:0];
        t30 = bl_reg[ST_ANG-1].t[30:0] << UP;
        m0  = {31'd0, ONE_30 - t30} * {31'd0, om};
        m1  = {31'd0, t30} * {31'd0, om};
        ang_reg[0] <= $signed({1'b0, m0[61:30]});
        ang_reg[1] <= $signed({1'b0, m1[61:30]});
    end

    // CORDIC rotation for the two sines.
    generate
        for (l = 0; l < 2; l++)
        begin : g_sin_lane
            for (k = 0; k < CORDIC_STEPS; k++)
            begin : g_sin
                logic signed [33:0] x_in, y_in;
                logic signed [32:0] z_in;
                if (k == 0)
                begin : g_first
                    assign x_in = $signed({3'b000, INV_GAIN});
                    assign y_in = '0;
                    assign z_in = ang_reg[l];
                end
                else
                begin : g_next
                    assign x_in = sn_x_reg[l][k-1];
                    assign y_in = sn_y_reg[l][k-1];
                    assign z_in = sn_z_reg[l][k-1];
                end
                always_ff @(posedge clk)
                begin
                    if (z_in >= 33'sd0)
                    begin
                        sn_x_reg[l][k] <= x_in - (y_in >>> k);
                        sn_y_reg[l][k] <= y_in + (x_in >>> k);
                        sn_z_reg[l][k] <= z_in - $signed({2'b00, ATAN_TAB[k]});
                    end
                    else
                    begin
                        sn_x_reg[l][k] <= x_in + (y_in >>> k);
                        sn_y_reg[l][k] <= y_in - (x_in >>> k);
                        sn_z_reg[l][k] <= z_in + $signed({2'b00, ATAN_TAB[k]});
                    end
                end
            end

            // Sine clamp and the weight overflow check.
            always_ff @(posedge clk)
            begin
                logic signed [33:0] y;
                logic [30:0]        sv;
                logic [61:0]        num, lim;
                y = sn_y_reg[l][CORDIC_STEPS-1];
                if (y < 34'sd0)
                begin
                    sv = '0;
                end
                else if (y > $signed({3'b000, ONE_30}))
                begin
                    sv = ONE_30;
                end
                else
                begin
                    sv = y[30:0];
                end
                num = {1'b0, sv, 30'd0};
                lim = {1'b0, sn_ln_reg[ST_DIVC-1], 30'd0} + 62'(sn_ln_reg[ST_DIVC-1]);
                dc_ovf_reg[l] <= (num >= lim);
                dc_rem_reg[l] <= 32'(sv >> 1);
                dc_bit_reg[l] <= sv[0];
            end

            // Restoring division sin / sn, one quotient bit per stage.
            for (k = 0; k < DIV_STEPS; k++)
            begin : g_div
                logic [31:0] rem_in;
                logic [30:0] q_in;
                logic        ovf_in, bit_in;
                logic [32:0] r2;
                logic [32:0] dvs;
                if (k == 0)
                begin : g_first
                    assign rem_in = dc_rem_reg[l];
                    assign q_in   = '0;
                    assign ovf_in = dc_ovf_reg[l];
                    assign bit_in = dc_bit_reg[l];
                end
                else
                begin : g_next
                    assign rem_in = dv_rem_reg[l][k-1];
                    assign q_in   = dv_q_reg[l][k-1];
                    assign ovf_in = dv_ovf_reg[l][k-1];
                    assign bit_in = 1'b0;
                end
                assign r2  = {rem_in, bit_in};
                assign dvs = {2'b00, sn_ln_reg[ST_DIV+k-1]};
                always_ff @(posedge clk)
                begin
                    dv_ovf_reg[l][k] <= ovf_in;
                    if (r2 >= dvs)
                    begin
                        dv_rem_reg[l][k] <= 32'(r2 - dvs);
                        dv_q_reg[l][k]   <= {q_in[29:0], 1'b1};
                    end
                    else
                    begin
                        dv_rem_reg[l][k] <= r2[31:0];
                        dv_q_reg[l][k]   <= {q_in[29:0], 1'b0};
                    end
                end
            end
        end
    endgenerate

    // Weight selection by word kind.
    always_ff @(posedge clk)
    begin
        item_t              it;
        logic [30:0]        t30, wq0, wq1;
        logic signed [31:0] w1;
        it  = bl_reg[ST_WGT-1];
        t30 = it.t[30:0] << UP;
        wq0 = dv_ovf_reg[0][DIV_STEPS-1] ? ONE_30 : dv_q_reg[0][DIV_STEPS-1];
        wq1 = dv_ovf_reg[1][DIV_STEPS-1] ? ONE_30 : dv_q_reg[1][DIV_STEPS-1];
        case (it.kind)
            KIND_TO:
            begin
                w0_reg <= '0;
                w1_reg <= $signed({1'b0, ONE_30});
            end
            KIND_LINEAR:
            begin
                w1     = $signed({1'b0, t30});
                w0_reg <= $signed({1'b0, ONE_30 - t30});
                w1_reg <= it.c_neg ? -w1 : w1;
            end
            KIND_TRIG:
            begin
                w1     = $signed({1'b0, wq1});
                w0_reg <= $signed({1'b0, wq0});
                w1_reg <= it.c_neg ? -w1 : w1;
            end
            default:
            begin
                w0_reg <= $signed({1'b0, ONE_30});
                w1_reg <= '0;
            end
        endcase
    end

    // Weighted products, then the sum with saturation.
    always_ff @(posedge clk)
    begin
        logic signed [64:0] sum, sh;
        for (int i = 0; i < 4; i++)
        begin
            pr0_reg[i] <= w0_reg * $signed(bl_reg[ST_WGT].f[i]);
            pr1_reg[i] <= w1_reg * $signed(bl_reg[ST_WGT].g[i]);
        end
        for (int i = 0; i < 4; i++)
        begin
            sum = 65'(pr0_reg[i]) + 65'(pr1_reg[i]);
            sh  = sum >>> 30;
            if (sh > 65'sh0_7FFF_FFFF)
            begin
                out_reg[i] <= 32'h7FFF_FFFF;
            end
            else if (sh < -65'sh0_8000_0000)
            begin
                out_reg[i] <= 32'h8000_0000;
            end
            else
            begin
                out_reg[i] <= sh[31:0];
            end
        end
    end

    assign done   = done_reg;
    assign result = out_reg;

endmodule

`default_nettype wire

// ===== design/quaternion_slerp.sv =====
// ----------------------------------------------------------------------------
// quaternion_slerp
// Fixed-point spherical linear interpolation of two quaternions.
// ----------------------------------------------------------------------------
// The block takes one word per clock while busy is low: a start and an end
// quaternion and a blend factor, all signed with FRACTION_BITS fraction
// bits. Each word gives one result, shown for a single cycle with done
// high; the receiver cannot stall. The back-end pipeline holds a square
// root with one root bit per stage, two 31-stage CORDIC units and a
// 31-stage divider. busy rises only if the queue between front and back
// end nears full, which the free-running back end does not allow in
// normal use. Configuration writes are always ready and must be made
// while no word is in flight.
`default_nettype none

module quaternion_slerp
    import qslerp_pkg::*;
#(
    parameter int FRACTION_BITS = 30
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] from_x,
    input  logic signed [31:0] from_y,
    input  logic signed [31:0] from_z,
    input  logic signed [31:0] from_w,
    input  logic signed [31:0] to_x,
    input  logic signed [31:0] to_y,
    input  logic signed [31:0] to_z,
    input  logic signed [31:0] to_w,
    input  logic signed [31:0] blend,
    output logic               done,
    output logic signed [31:0] out_x,
    output logic signed [31:0] out_y,
    output logic signed [31:0] out_z,
    output logic signed [31:0] out_w,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_index,
    input  logic [30:0]        cfg_data
);

    logic [30:0]      equal_tolerance_reg;
    logic [30:0]      parallel_threshold_reg;
    logic             accept;
    logic             q_push;
    item_t            q_push_item;
    item_t            q_head;
    queue_status_t    q_stat;
    logic [3:0][31:0] result;

    // Configuration registers.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            equal_tolerance_reg    <= EQUAL_TOLERANCE_RESET;
            parallel_threshold_reg <= PARALLEL_THRESHOLD_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_EQUAL_TOLERANCE:    equal_tolerance_reg    <= cfg_data;
                REG_PARALLEL_THRESHOLD: parallel_threshold_reg <= cfg_data;
                default:                equal_tolerance_reg    <= equal_tolerance_reg;
            endcase
        end
    end

    // Accept while the queue has room for everything in the front end.
    assign busy   = (q_stat.count > QUEUE_CW'(QUEUE_DEPTH - QUEUE_SLACK));
    assign accept = start && !busy;

    qslerp_front #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_front (
        .clk                (clk),
        .rst_n              (rst_n),
        .accept             (accept),
        .from_q             ({from_w, from_z, from_y, from_x}),
        .to_q               ({to_w, to_z, to_y, to_x}),
        .blend              (blend),
        .equal_tolerance    (equal_tolerance_reg),
        .parallel_threshold (parallel_threshold_reg),
        .push               (q_push),
        .push_item          (q_push_item)
    );

    qslerp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_push_item),
        .pop       (!q_stat.empty),
        .head_item (q_head),
        .status    (q_stat)
    );

    qslerp_back #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (!q_stat.empty),
        .in_item  (q_head),
        .done     (done),
        .result   (result)
    );

    assign out_x = result[0];
    assign out_y = result[1];
    assign out_z = result[2];
    assign out_w = result[3];

`ifndef SYNTHESIS
    // The front end never pushes into a full queue.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_stat.full)
        else $error("slerp queue overflow");

    // The back end drains one word per cycle, so the queue holds at most one.
    a_drained: assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.count <= QUEUE_CW'(1))
        else $error("slerp queue not drained");

    // A word accepted is always taken: busy never rises without a backlog in the queue.
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !q_stat.full |-> !busy || (q_stat.count > QUEUE_CW'(1)))
        else $error("slerp busy without backlog");
`endif

endmodule

`default_nettype wire
